// ----- hw/rtl/a52ks_pkg.sv -----
// a52ks_pkg: item types, sequencing constants and control structs for the
// A5/2 keystream generator. Depends on nothing; every rtl file imports it.
package a52ks_pkg;

  localparam int KEY_BITS         = 64;
  localparam int FRAME_BITS       = 22;
  localparam int LOAD_BITS        = KEY_BITS + FRAME_BITS;
  localparam int WARMUP_CLOCKS    = 100;
  localparam int OUTPUT_WORD_BITS = 32;

  localparam int COUNT_W = 6;
  localparam int INDEX_W = $clog2(OUTPUT_WORD_BITS);
  localparam int STEP_W  = 7;

  localparam logic CMD_SETUP    = 1'b0;
  localparam logic CMD_GENERATE = 1'b1;

  typedef struct packed {
    logic        command;
    logic [31:0] key_low;
    logic [31:0] key_high;
    logic [21:0] frame_number;
    logic [5:0]  bit_count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] keystream_bits;
    logic [5:0]  valid_bits;
  } out_item_t;

  // lfsr bank controls, at most one of clear/load/force/step per cycle
  typedef struct packed {
    logic clear;
    logic load;
    logic load_bit;
    logic force_bits;
    logic step_maj;
  } lfsr_ctrl_t;

  typedef struct packed {
    logic               start;
    logic               write;
    logic               publish;
    logic [INDEX_W-1:0] index;
    logic [COUNT_W-1:0] count;
  } coll_ctrl_t;

endpackage

// ----- hw/rtl/a52_keystream_generator_top.sv -----
// a52_keystream_generator_top: A5/2 keystream generator top level.
// Depends on a52ks_pkg, a52ks_sequencer, a52ks_lfsr_bank, a52ks_collector.
//
// One item at a time, one lfsr clock per cycle. A setup item (key and frame)
// goes from acceptance to its result through the serial load of its 86 key
// and frame bits, the forcing of the constant bits, the majority warm-up
// clocks and the registering of the result; it returns zero bits with a
// count of zero. A generate item for n bits (bit_count saturated to 32)
// collects one keystream bit per clock of the registers, then registers its
// result. The next item is accepted in the cycle after the result is
// registered, even while that result still waits in the output register; a
// result waits in its final cycle only if the output register is still occupied.
module a52_keystream_generator_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  a52ks_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output a52ks_pkg::out_item_t out_data
);
  import a52ks_pkg::*;

  lfsr_ctrl_t lfsr_ctrl;
  coll_ctrl_t coll_ctrl;
  logic       ks_bit;
  logic       slot_free;

  a52ks_sequencer u_sequencer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .slot_free (slot_free),
    .lfsr_ctrl (lfsr_ctrl),
    .coll_ctrl (coll_ctrl)
  );

  a52ks_lfsr_bank u_lfsr_bank (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (lfsr_ctrl),
    .ks_bit (ks_bit)
  );

  a52ks_collector u_collector (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (coll_ctrl),
    .ks_bit    (ks_bit),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/a52ks_lfsr_bank.sv -----
// a52ks_lfsr_bank: the four A5/2 shift registers, their clocking modes and
// the combinational keystream bit. Depends on a52ks_pkg.
module a52ks_lfsr_bank (
  input  logic                 clk,
  input  logic                 rst,
  input  a52ks_pkg::lfsr_ctrl_t ctrl,
  output logic                 ks_bit
);
  import a52ks_pkg::*;

  logic [18:0] r1;
  logic [21:0] r2;
  logic [22:0] r3;
  logic [16:0] rc;

  logic fb1, fb2, fb3, fbc;
  logic m, en1, en2, en3;

  function automatic logic maj3(input logic a, input logic b, input logic c);
    maj3 = (a & b) | (a & c) | (b & c);
  endfunction

  assign fb1 = r1[18] ^ r1[17] ^ r1[16] ^ r1[13];
  assign fb2 = r2[21] ^ r2[20];
  assign fb3 = r3[22] ^ r3[21] ^ r3[20] ^ r3[7];
  assign fbc = rc[16] ^ rc[11];

  assign m   = maj3(rc[10], rc[3], rc[7]);
  assign en1 = (rc[10] == m);
  assign en2 = (rc[3] == m);
  assign en3 = (rc[7] == m);

  assign ks_bit = r1[18] ^ r2[21] ^ r3[22]
                ^ maj3(r1[15], ~r1[14], r1[12])
                ^ maj3(~r2[16], r2[13], r2[9])
                ^ maj3(r3[18], r3[16], ~r3[13]);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      r1 <= '0;
      r2 <= '0;
      r3 <= '0;
      rc <= '0;
    end else if (ctrl.load) begin
      // clock all, then fold the loaded bit into bit 0
      r1 <= {r1[17:0], fb1 ^ ctrl.load_bit};
      r2 <= {r2[20:0], fb2 ^ ctrl.load_bit};
      r3 <= {r3[21:0], fb3 ^ ctrl.load_bit};
      rc <= {rc[15:0], fbc ^ ctrl.load_bit};
    end else if (ctrl.force_bits) begin
      r1[15] <= 1'b1;
      r2[16] <= 1'b1;
      r3[18] <= 1'b1;
      rc[10] <= 1'b1;
    end else if (ctrl.step_maj) begin
      if (en1) r1 <= {r1[17:0], fb1};
      if (en2) r2 <= {r2[20:0], fb2};
      if (en3) r3 <= {r3[21:0], fb3};
      rc <= {rc[15:0], fbc};
    end
  end

endmodule

// ----- hw/rtl/a52ks_collector.sv -----
// a52ks_collector: gathers keystream bits one per cycle into a word and holds
// the finished result item in the output register. Depends on a52ks_pkg.
module a52ks_collector (
  input  logic                  clk,
  input  logic                  rst,
  input  a52ks_pkg::coll_ctrl_t ctrl,
  input  logic                  ks_bit,
  output logic                  slot_free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output a52ks_pkg::out_item_t  out_data
);
  import a52ks_pkg::*;

  logic [OUTPUT_WORD_BITS-1:0] acc;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      acc <= '0;
    end else if (ctrl.write) begin
      acc[ctrl.index] <= ks_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.publish) begin
      out_data.keystream_bits <= acc;
      out_data.valid_bits     <= ctrl.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/a52ks_sequencer.sv -----
// a52ks_sequencer: input handshake, serial key/frame shift register and the
// state machine that steps the lfsr bank and collector. Depends on a52ks_pkg.
module a52ks_sequencer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  a52ks_pkg::in_item_t   in_data,
  input  logic                  slot_free,
  output a52ks_pkg::lfsr_ctrl_t lfsr_ctrl,
  output a52ks_pkg::coll_ctrl_t coll_ctrl
);
  import a52ks_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_FORCE = 6'b000100,
    S_WARM  = 6'b001000,
    S_GEN   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t              state, state_next;
  logic [LOAD_BITS-1:0] load_sr;
  logic [STEP_W-1:0]   cnt;
  logic [COUNT_W-1:0]  gen_n;
  logic [COUNT_W-1:0]  sat_n;
  logic                accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign sat_n = (in_data.bit_count > COUNT_W'(OUTPUT_WORD_BITS))
               ? COUNT_W'(OUTPUT_WORD_BITS) : in_data.bit_count;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_data.command == CMD_SETUP) state_next = S_LOAD;
          else if (sat_n == '0)            state_next = S_DONE;
          else                             state_next = S_GEN;
        end
      end
      S_LOAD: begin
        if (cnt == STEP_W'(LOAD_BITS - 1)) state_next = S_FORCE;
      end
      S_FORCE: state_next = S_WARM;
      S_WARM: begin
        if (cnt == STEP_W'(WARMUP_CLOCKS - 1)) state_next = S_DONE;
      end
      S_GEN: begin
        if (cnt == (STEP_W'(gen_n) - STEP_W'(1))) state_next = S_DONE;
      end
      S_DONE: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (accept || state == S_FORCE) begin
      cnt <= '0;
    end else if (state == S_LOAD || state == S_WARM || state == S_GEN) begin
      cnt <= cnt + STEP_W'(1);
    end
  end

  // key bits first, low bit first, then the frame number
  always_ff @(posedge clk) begin
    if (accept) begin
      load_sr <= {in_data.frame_number, in_data.key_high, in_data.key_low};
    end else if (state == S_LOAD) begin
      load_sr <= {1'b0, load_sr[LOAD_BITS-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      gen_n <= (in_data.command == CMD_SETUP) ? '0 : sat_n;
    end
  end

  always_comb begin
    lfsr_ctrl.clear      = accept && (in_data.command == CMD_SETUP);
    lfsr_ctrl.load       = (state == S_LOAD);
    lfsr_ctrl.load_bit   = load_sr[0];
    lfsr_ctrl.force_bits = (state == S_FORCE);
    lfsr_ctrl.step_maj   = (state == S_WARM) || (state == S_GEN);

    coll_ctrl.start   = accept;
    coll_ctrl.write   = (state == S_GEN);
    coll_ctrl.publish = (state == S_DONE) && slot_free;
    coll_ctrl.index   = cnt[INDEX_W-1:0];
    coll_ctrl.count   = gen_n;
  end

endmodule

// ----- test/a52_keystream_generator_top_tb.sv -----
`timescale 1ns / 1ps
// a52_keystream_generator_top_tb: self-checking bench for the A5/2 keystream generator.
// Depends on a52ks_pkg and a52_keystream_generator_top; all results are predicted in-bench.
module a52_keystream_generator_top_tb;
  import a52ks_pkg::*;

  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 200;
  localparam int MAX_REPORTS   = 10;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // predicted cipher state
  logic [18:0] r1 = '0;
  logic [21:0] r2 = '0;
  logic [22:0] r3 = '0;
  logic [16:0] rc = '0;

  out_item_t keystream_q[$];
  out_item_t want;

  int mismatches      = 0;
  int results_checked = 0;
  int setups_sent     = 0;
  int generates_sent  = 0;
  int bits_requested  = 0;
  int stall_cycles    = 0;

  a52_keystream_generator_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  function automatic logic maj3(logic a, logic b, logic c);
    return (a & b) | (a & c) | (b & c);
  endfunction

  // enables are sampled before any register moves
  function automatic void clock_registers(logic e1, logic e2, logic e3);
    if (e1) r1 = {r1[17:0], r1[18] ^ r1[17] ^ r1[16] ^ r1[13]};
    if (e2) r2 = {r2[20:0], r2[21] ^ r2[20]};
    if (e3) r3 = {r3[21:0], r3[22] ^ r3[21] ^ r3[20] ^ r3[7]};
    rc = {rc[15:0], rc[16] ^ rc[11]};
  endfunction

  function automatic void clock_majority();
    logic m;
    m = maj3(rc[10], rc[3], rc[7]);
    clock_registers(rc[10] == m, rc[3] == m, rc[7] == m);
  endfunction

  function automatic void load_bit(logic b);
    clock_registers(1'b1, 1'b1, 1'b1);
    r1[0] = r1[0] ^ b;
    r2[0] = r2[0] ^ b;
    r3[0] = r3[0] ^ b;
    rc[0] = rc[0] ^ b;
  endfunction

  function automatic logic keystream_bit();
    return r1[18] ^ r2[21] ^ r3[22]
         ^ maj3(r1[15], ~r1[14], r1[12])
         ^ maj3(~r2[16], r2[13], r2[9])
         ^ maj3(r3[18], r3[16], ~r3[13]);
  endfunction

  function automatic out_item_t predict_keystream(in_item_t it);
    out_item_t   res;
    logic [63:0] key;
    int          n;
    res = '0;
    if (it.command == CMD_SETUP) begin
      key = {it.key_high, it.key_low};
      r1 = '0;
      r2 = '0;
      r3 = '0;
      rc = '0;
      for (int i = 0; i < KEY_BITS; i++) load_bit(key[i]);
      for (int i = 0; i < FRAME_BITS; i++) load_bit(it.frame_number[i]);
      r1[15] = 1'b1;
      r2[16] = 1'b1;
      r3[18] = 1'b1;
      rc[10] = 1'b1;
      for (int i = 0; i < WARMUP_CLOCKS; i++) clock_majority();
    end else begin
      // oversized counts saturate to a full word
      n = (int'(it.bit_count) > OUTPUT_WORD_BITS) ? OUTPUT_WORD_BITS : int'(it.bit_count);
      for (int i = 0; i < n; i++) begin
        res.keystream_bits[i] = keystream_bit();
        clock_majority();
      end
      res.valid_bits = 6'(n);
    end
    return res;
  endfunction

  function automatic in_item_t make_item(logic cmd, logic [5:0] count);
    in_item_t it;
    it.command      = cmd;
    it.key_low      = $urandom();
    it.key_high     = $urandom();
    it.frame_number = 22'($urandom());
    it.bit_count    = count;
    return it;
  endfunction

  function automatic logic [5:0] random_count();
    case ($urandom_range(19))
      0:       return 6'd0;
      1:       return 6'($urandom_range(63, 33));
      default: return 6'($urandom_range(32, 1));
    endcase
  endfunction

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    keystream_q.push_back(predict_keystream(it));
    if (it.command == CMD_SETUP) begin
      setups_sent++;
    end else begin
      generates_sent++;
      bits_requested += int'(it.bit_count);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (keystream_q.size() != 0) @(posedge clk);
  endtask

  // all-zero state stays all zero
  task automatic test_generate_from_reset();
    send_item(make_item(CMD_GENERATE, 6'd0));
    send_item(make_item(CMD_GENERATE, 6'd1));
    send_item(make_item(CMD_GENERATE, 6'd32));
    send_item(make_item(CMD_GENERATE, 6'd63));
  endtask

  task automatic test_key_extremes();
    in_item_t it;
    it = make_item(CMD_SETUP, 6'd0);
    it.key_low      = '0;
    it.key_high     = '0;
    it.frame_number = '0;
    send_item(it);
    send_item(make_item(CMD_GENERATE, 6'd32));
    it = make_item(CMD_SETUP, 6'd63);
    it.key_low      = '1;
    it.key_high     = '1;
    it.frame_number = '1;
    send_item(it);
    send_item(make_item(CMD_GENERATE, 6'd32));
    it = make_item(CMD_SETUP, 6'd32);
    it.key_low      = 32'haaaa_aaaa;
    it.key_high     = 32'h5555_5555;
    it.frame_number = 22'h2a_aaaa;
    send_item(it);
    send_item(make_item(CMD_GENERATE, 6'd17));
  endtask

  task automatic test_bit_count_limits();
    logic [5:0] counts [11] = '{6'd0, 6'd1, 6'd2, 6'd4, 6'd8, 6'd16, 6'd31, 6'd32,
                                6'd33, 6'd63, 6'd3};
    send_item(make_item(CMD_SETUP, 6'd5));
    foreach (counts[i]) send_item(make_item(CMD_GENERATE, counts[i]));
  endtask

  // mostly a setup followed by a few generates, some stray items mixed in
  task automatic test_random_sessions(int n_items);
    in_item_t it;
    int       sent;
    int       gens;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_item(make_item(($urandom_range(1) == 1) ? CMD_GENERATE : CMD_SETUP,
                            random_count()));
        sent++;
      end else begin
        it = make_item(CMD_SETUP, random_count());
        case ($urandom_range(15))
          0: begin
            it.key_low  = '0;
            it.key_high = '0;
          end
          1: begin
            it.key_low      = '1;
            it.key_high     = '1;
            it.frame_number = '1;
          end
          default: ;
        endcase
        send_item(it);
        sent++;
        gens = $urandom_range(6, 1);
        for (int g = 0; g < gens; g++) begin
          send_item(make_item(CMD_GENERATE, random_count()));
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (keystream_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: bits=%h count=%0d",
                   out_data.keystream_bits, out_data.valid_bits);
      end else begin
        want = keystream_q.pop_front();
        results_checked++;
        if (out_data.keystream_bits !== want.keystream_bits ||
            out_data.valid_bits !== want.valid_bits) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d: expected bits=%h count=%0d, got bits=%h count=%0d",
                     results_checked, want.keystream_bits, want.valid_bits,
                     out_data.keystream_bits, out_data.valid_bits);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("no item moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, keystream_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 29;
    recv_idle_pct = 85;
    test_generate_from_reset();
    test_key_extremes();
    test_bit_count_limits();
    test_random_sessions(170);
    wait_for_results();

    send_idle_pct = 85;
    recv_idle_pct = 29;
    test_random_sessions(170);
    wait_for_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_sessions(170);
    wait_for_results();

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("ran %0d setups and %0d generates (%0d bits asked) under three idle mixes",
             setups_sent, generates_sent, bits_requested);
    $display("%0d results checked, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && keystream_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (keystream_q.size() != 0)
        $display("%0d results never arrived", keystream_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
